@@ hw/rtl/lprf_pkg.sv @@
`timescale 1ns / 1ps

package lprf_pkg;

  localparam int RING_BYTES_DEF   = 256;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int MAX_READ_DEF     = 64;

  localparam int FUNC_W   = 3;
  localparam int LEN_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int MAXLEN_W = 7;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 9;

  localparam logic [FUNC_W-1:0] F_PUSH_START = 3'd0;
  localparam logic [FUNC_W-1:0] F_PUSH_BYTE  = 3'd1;
  localparam logic [FUNC_W-1:0] F_POP        = 3'd2;
  localparam logic [FUNC_W-1:0] F_PEEK       = 3'd3;
  localparam logic [FUNC_W-1:0] F_CLEAR      = 3'd4;
  localparam logic [FUNC_W-1:0] F_CHECK_FIT  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_BYTE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data;
    logic                byte_valid;
    logic                last;
    logic [FREE_W-1:0]   free_bytes;
    logic                is_empty;
  } res_t;

endpackage

@@ hw/rtl/lprf_ring_mem.sv @@
`timescale 1ns / 1ps

module lprf_ring_mem #(
  parameter int DEPTH = lprf_pkg::RING_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lprf_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [lprf_pkg::BYTE_W-1:0] rd_data
);
  import lprf_pkg::*;

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/lprf_ctrl.sv @@
`timescale 1ns / 1ps

module lprf_ctrl #(
  parameter int RING_BYTES   = lprf_pkg::RING_BYTES_DEF,
  parameter int HEADER_BYTES = lprf_pkg::HEADER_BYTES_DEF,
  parameter int MAX_READ     = lprf_pkg::MAX_READ_DEF,
  parameter int AW           = $clog2(RING_BYTES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lprf_pkg::FUNC_W-1:0]   in_func,
  input  logic [lprf_pkg::LEN_W-1:0]    in_record_len,
  input  logic [lprf_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [lprf_pkg::MAXLEN_W-1:0] in_max_len,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lprf_pkg::res_t                res,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [lprf_pkg::BYTE_W-1:0]   mem_wr_data,
  output logic                          mem_rd_en,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic [lprf_pkg::BYTE_W-1:0]   mem_rd_data
);
  import lprf_pkg::*;

  localparam int FCW = $clog2(RING_BYTES + 1);
  localparam int CW  = ((FCW > FREE_W) ? FCW : FREE_W) + 1;
  localparam int SW  = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int HIW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int NW  = MAXLEN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDRW = 3'd1;
  localparam logic [2:0] S_HDRR = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_LEN  = 3'd4;
  localparam logic [2:0] S_BODY = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       rp_r, rp_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [AW-1:0]       p_r, p_nxt;
  logic [FCW-1:0]      fc_r, fc_nxt;
  logic [LEN_W-1:0]    left_r, left_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [MAXLEN_W-1:0] mlen_r, mlen_nxt;
  logic [HIW-1:0]      idx_r, idx_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic                pop_r, pop_nxt;
  logic                cap_r, cap_nxt;

  logic                in_fire;
  logic                fits;
  logic [CW-1:0]       need;
  logic [CW-1:0]       fc_sum;
  logic [SW-1:0]       p_sum;
  logic [LEN_W-1:0]    n_len;
  logic [NW-1:0]       n_cnt;
  logic [AW-1:0]       wp_inc, p_inc;
  logic                last_idx;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] q;
    q = (p == AW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
    return q;
  endfunction

  assign in_ready = (state_r == S_IDLE) && res_ready;
  assign in_fire  = in_valid && in_ready;

  assign need     = CW'(in_record_len) + CW'(HEADER_BYTES);
  assign fits     = CW'(fc_r) >= need;
  assign wp_inc   = ptr_inc(wp_r);
  assign p_inc    = ptr_inc(p_r);
  assign last_idx = idx_r == HIW'(HEADER_BYTES - 1);

  always_comb begin
    fc_sum = CW'(fc_r) + CW'(len_r) + CW'(HEADER_BYTES);
    p_sum  = SW'(p_r) + SW'(len_r);
    if (p_sum >= SW'(RING_BYTES)) begin
      p_sum = p_sum - SW'(RING_BYTES);
    end
    n_len = (len_r < LEN_W'(mlen_r)) ? len_r : LEN_W'(mlen_r);
    if (n_len > LEN_W'(MAX_READ)) begin
      n_len = LEN_W'(MAX_READ);
    end
    n_cnt = n_len[NW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    p_nxt     = p_r;
    fc_nxt    = fc_r;
    left_nxt  = left_r;
    len_nxt   = cap_r ? mem_rd_data : len_r;
    mlen_nxt  = mlen_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    pop_nxt   = pop_r;
    cap_nxt   = 1'b0;

    mem_wr_en   = 1'b0;
    mem_wr_addr = wp_r;
    mem_wr_data = in_data_byte;
    mem_rd_en   = 1'b0;
    mem_rd_addr = p_r;

    res_valid      = 1'b0;
    res.status     = ST_OK;
    res.data       = '0;
    res.byte_valid = 1'b0;
    res.last       = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            F_PUSH_START: begin
              res_valid = 1'b1;
              if (left_r != '0 || !fits) begin
                res.status = ST_REFUSED;
              end else begin
                fc_nxt    = FCW'(CW'(fc_r) - need);
                left_nxt  = in_record_len;
                len_nxt   = in_record_len;
                idx_nxt   = '0;
                state_nxt = S_HDRW;
              end
            end
            F_PUSH_BYTE: begin
              res_valid = 1'b1;
              if (left_r == '0) begin
                res.status = ST_BAD_BYTE;
              end else begin
                mem_wr_en = 1'b1;
                wp_nxt    = wp_inc;
                left_nxt  = left_r - 1'b1;
              end
            end
            F_POP, F_PEEK: begin
              if (left_r != '0) begin
                res_valid  = 1'b1;
                res.status = ST_REFUSED;
              end else if (fc_r == FCW'(RING_BYTES)) begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                p_nxt     = rp_r;
                idx_nxt   = '0;
                mlen_nxt  = in_max_len;
                pop_nxt   = (in_func == F_POP);
                state_nxt = S_HDRR;
              end
            end
            F_CLEAR: begin
              res_valid = 1'b1;
              rp_nxt    = wp_r;
              fc_nxt    = FCW'(RING_BYTES);
              left_nxt  = '0;
            end
            F_CHECK_FIT: begin
              res_valid  = 1'b1;
              res.status = fits ? ST_OK : ST_REFUSED;
            end
            default: begin
              res_valid  = 1'b1;
              res.status = ST_REFUSED;
            end
          endcase
        end
      end
      S_HDRW: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = (idx_r == '0) ? len_r : '0;
        wp_nxt      = wp_inc;
        idx_nxt     = idx_r + 1'b1;
        if (last_idx) begin
          state_nxt = S_IDLE;
        end
      end
      S_HDRR: begin
        mem_rd_en = 1'b1;
        p_nxt     = p_inc;
        idx_nxt   = idx_r + 1'b1;
        cap_nxt   = (idx_r == '0);
        if (last_idx) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_LEN;
      end
      S_LEN: begin
        if (n_cnt != '0 || res_ready) begin
          if (pop_r) begin
            fc_nxt = (fc_sum > CW'(RING_BYTES)) ? FCW'(RING_BYTES) : fc_sum[FCW-1:0];
            rp_nxt = p_sum[AW-1:0];
          end
          if (n_cnt == '0) begin
            res_valid = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = n_cnt;
            state_nxt = S_BODY;
          end
        end
      end
      S_BODY: begin
        mem_rd_en = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) begin
          res_valid      = 1'b1;
          res.data       = mem_rd_data;
          res.byte_valid = 1'b1;
          res.last       = (cnt_r == NW'(1));
          p_nxt          = p_inc;
          cnt_nxt        = cnt_r - 1'b1;
          state_nxt      = (cnt_r == NW'(1)) ? S_IDLE : S_BODY;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.free_bytes = FREE_W'(fc_nxt);
    res.is_empty   = (fc_nxt == FCW'(RING_BYTES));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rp_r    <= '0;
      wp_r    <= '0;
      fc_r    <= FCW'(RING_BYTES);
      left_r  <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      pop_r   <= 1'b0;
      cap_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      fc_r    <= fc_nxt;
      left_r  <= left_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      pop_r   <= pop_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    len_r  <= len_nxt;
    mlen_r <= mlen_nxt;
  end

endmodule

@@ hw/rtl/length_prefixed_record_ring_fifo.sv @@
`timescale 1ns / 1ps
// Push_byte, clear, check_fit and refused items are answered when accepted; the result
// sits in the output register on the next cycle. An accepted push_start is answered, then
// writes the header bytes. Pop and peek read the header through the single read port of
// the ring memory, whose read data is registered, then read and emit each returned byte.
// Reset clears the pointers, the pending push count and the output valid flag and sets
// the free count to RING_BYTES; the ring memory is not cleared.

module length_prefixed_record_ring_fifo #(
  parameter int RING_BYTES   = lprf_pkg::RING_BYTES_DEF,
  parameter int HEADER_BYTES = lprf_pkg::HEADER_BYTES_DEF,
  parameter int MAX_READ     = lprf_pkg::MAX_READ_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lprf_pkg::FUNC_W-1:0]   in_func,
  input  logic [lprf_pkg::LEN_W-1:0]    in_record_len,
  input  logic [lprf_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [lprf_pkg::MAXLEN_W-1:0] in_max_len,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lprf_pkg::STATUS_W-1:0] out_status,
  output logic [lprf_pkg::BYTE_W-1:0]   out_out_byte,
  output logic                          out_byte_valid,
  output logic                          out_last,
  output logic [lprf_pkg::FREE_W-1:0]   out_free_bytes,
  output logic                          out_is_empty
);
  import lprf_pkg::*;

  localparam int AW = $clog2(RING_BYTES);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [BYTE_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [BYTE_W-1:0] mem_rd_data;

  logic              out_valid_r;
  res_t              out_res_r;

  lprf_ctrl #(
    .RING_BYTES   (RING_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_READ     (MAX_READ),
    .AW           (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_record_len (in_record_len),
    .in_data_byte  (in_data_byte),
    .in_max_len    (in_max_len),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

  lprf_ring_mem #(
    .DEPTH (RING_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_out_byte   = out_res_r.data;
  assign out_byte_valid = out_res_r.byte_valid;
  assign out_last       = out_res_r.last;
  assign out_free_bytes = out_res_r.free_bytes;
  assign out_is_empty   = out_res_r.is_empty;

endmodule
